FILE: rtl/event_ring_queue_unit_assert.svh
// Assertion macros for the event ring queue; the clock is clock and the reset is reset.
`ifndef EVENT_RING_QUEUE_UNIT_ASSERT_SVH
`define EVENT_RING_QUEUE_UNIT_ASSERT_SVH

// Checks that cond implies expr in the same cycle, outside reset.
`define ERQ_ASSERT_SAME(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error(msg);

// Checks that cond implies expr in the next cycle, outside reset.
`define ERQ_ASSERT_NEXT(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error(msg);

// Checks that cond implies expr in the same cycle, also during reset.
`define ERQ_ASSERT_ALWAYS(label, cond, expr, msg) \
   label: assert property (@(posedge clock) (cond) |-> (expr)) \
      else $error(msg);

`endif

FILE: rtl/erq_pkg.sv
// Shared types and constants of the event ring queue.
package erq_pkg;

   localparam int CAP_W   = 6;
   localparam int DATA_W  = 64;
   localparam int SLOTS_W = 6;

   // Command codes of an input word.
   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_READ   = 2'd1;
   localparam logic [1:0] CMD_FLUSH  = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // Status codes of a result word.
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_INVALID = 2'd1;
   localparam logic [1:0] STATUS_NOSPACE = 2'd2;
   localparam logic [1:0] STATUS_EMPTY   = 2'd3;

   // Operation kinds passed from the front to the back.
   localparam logic [1:0] OP_INSERT  = 2'd0;
   localparam logic [1:0] OP_READ    = 2'd1;
   localparam logic [1:0] OP_FLUSH   = 2'd2;
   localparam logic [1:0] OP_INVALID = 2'd3;

   // Most events that one read returns.
   localparam logic [SLOTS_W-1:0] MAX_RESULTS = 6'd32;

   typedef struct packed {
      logic [1:0]         command;
      logic [DATA_W-1:0]  event_address;
      logic [DATA_W-1:0]  event_length;
      logic [DATA_W-1:0]  event_cookie;
      logic [SLOTS_W-1:0] read_slots;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic              has_event;
      logic [DATA_W-1:0] out_address;
      logic [DATA_W-1:0] out_length;
      logic [DATA_W-1:0] out_cookie;
      logic [CAP_W-1:0]  pending_count;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [SLOTS_W-1:0] slots;
      logic [DATA_W-1:0]  address;
      logic [DATA_W-1:0]  length;
      logic [DATA_W-1:0]  cookie;
   } op_type;

endpackage

FILE: rtl/erq_ram.sv
// Generic single write port, single read port RAM with registered read data.
module erq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/erq_fifo.sv
// Two-entry word queue used between the stages of the event ring queue.
module erq_fifo #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff;
   logic             wr_ptr_in;
   logic             rd_ptr_ff;
   logic             rd_ptr_in;
   logic [1:0]       count_ff;
   logic [1:0]       count_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage for the queued words.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/erq_front.sv
// Front part: accepts input words, classifies them and queues operations.
module erq_front
   import erq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   input  req_type req_word,
   output logic    req_full,
   output logic    op_valid,
   output op_type  op_word,
   input  logic    op_pop
);

   op_type decoded;
   logic   op_empty;

   // Classify the command; a read of zero slots and the unused code are invalid.
   always_comb begin
      decoded.address = req_word.event_address;
      decoded.length  = req_word.event_length;
      decoded.cookie  = req_word.event_cookie;
      decoded.slots   = (req_word.read_slots > MAX_RESULTS) ? MAX_RESULTS
                                                            : req_word.read_slots;
      unique case (req_word.command)
         CMD_INSERT: begin
            decoded.kind = OP_INSERT;
         end
         CMD_READ: begin
            decoded.kind = (req_word.read_slots == '0) ? OP_INVALID : OP_READ;
         end
         CMD_FLUSH: begin
            decoded.kind = OP_FLUSH;
         end
         CMD_UNUSED: begin
            decoded.kind = OP_INVALID;
         end
         default: begin
            decoded.kind = OP_INVALID;
         end
      endcase
   end

   // Short queue that decouples the input side from the back part.
   erq_fifo #(
      .WIDTH($bits(op_type))
   ) u_op_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (req_push),
      .push_data(decoded),
      .full     (req_full),
      .pop      (op_pop),
      .pop_data (op_word),
      .empty    (op_empty)
   );

   assign op_valid = !op_empty;

endmodule

FILE: rtl/erq_back.sv
// Back part: owns the ring state and memory and carries out each operation.
module erq_back
   import erq_pkg::*;
#(
   parameter int DEPTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   input  logic [CAP_W-1:0] csr_data,
   input  logic             op_valid,
   input  op_type           op_word,
   output logic             op_pop,
   output logic             res_push,
   output rsp_type          res_word,
   input  logic             res_full
);

   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SLOT_W = $clog2(DEPTH + 1);
   localparam int SUM_W  = SLOT_W + 1;
   localparam int CMP_W  = ((SLOT_W > CAP_W) ? SLOT_W : CAP_W) + 1;
   localparam int RAM_W  = 3 * DATA_W;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_READ = 1'b1;

   logic               state_ff;
   logic               state_in;
   logic [SLOT_W-1:0]  slots_ff;
   logic [SLOT_W-1:0]  slots_in;
   logic [SLOT_W-1:0]  pending_ff;
   logic [SLOT_W-1:0]  pending_in;
   logic [IDX_W-1:0]   wr_idx_ff;
   logic [IDX_W-1:0]   wr_idx_in;
   logic [IDX_W-1:0]   rd_idx_ff;
   logic [IDX_W-1:0]   rd_idx_in;
   logic               ovf_ff;
   logic               ovf_in;
   logic [SLOTS_W-1:0] left_ff;
   logic [SLOTS_W-1:0] left_in;
   logic               ram_we;
   logic [RAM_W-1:0]   ram_rd_data;

   // Next ring index; wraps at the slots in use and at the memory depth.
   function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx,
                                                input logic [SLOT_W-1:0] slots);
      logic [SUM_W-1:0] nxt;
      nxt = SUM_W'(idx) + SUM_W'(1);
      if (nxt >= SUM_W'(slots) || nxt >= SUM_W'(DEPTH)) begin
         return '0;
      end
      return nxt[IDX_W-1:0];
   endfunction

   // Capacity write, saturated to the memory depth.
   always_comb begin
      slots_in = slots_ff;
      if (csr_valid) begin
         if (CMP_W'(csr_data) > CMP_W'(DEPTH)) begin
            slots_in = SLOT_W'(DEPTH);
         end else begin
            slots_in = SLOT_W'(csr_data);
         end
      end
   end

   // Operation sequencer: single-word ops; reads one event a cycle while res_full is low.
   always_comb begin
      state_in   = state_ff;
      pending_in = pending_ff;
      wr_idx_in  = wr_idx_ff;
      rd_idx_in  = rd_idx_ff;
      ovf_in     = ovf_ff;
      left_in    = left_ff;
      op_pop     = 1'b0;
      res_push   = 1'b0;
      ram_we     = 1'b0;
      res_word   = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (op_valid && !res_full) begin
               op_pop        = 1'b1;
               res_push      = 1'b1;
               res_word.last = 1'b1;
               unique case (op_word.kind)
                  OP_INSERT: begin
                     if (pending_ff >= slots_ff) begin
                        ovf_in          = 1'b1;
                        res_word.status = STATUS_NOSPACE;
                     end else begin
                        ram_we          = 1'b1;
                        wr_idx_in       = advance(wr_idx_ff, slots_ff);
                        pending_in      = pending_ff + SLOT_W'(1);
                        res_word.status = STATUS_OK;
                     end
                  end
                  OP_FLUSH: begin
                     wr_idx_in       = '0;
                     rd_idx_in       = '0;
                     pending_in      = '0;
                     ovf_in          = 1'b0;
                     res_word.status = STATUS_OK;
                  end
                  OP_INVALID: begin
                     res_word.status = STATUS_INVALID;
                  end
                  OP_READ: begin
                     if (ovf_ff) begin
                        res_word.status = STATUS_NOSPACE;
                     end else if (pending_ff == '0) begin
                        res_word.status = STATUS_EMPTY;
                     end else begin
                        res_push = 1'b0;
                        left_in  = op_word.slots;
                        state_in = S_READ;
                     end
                  end
                  default: begin
                     res_word.status = STATUS_INVALID;
                  end
               endcase
               res_word.pending_count = CAP_W'(pending_in);
            end
         end
         S_READ: begin
            if (!res_full) begin
               res_push               = 1'b1;
               pending_in             = pending_ff - SLOT_W'(1);
               rd_idx_in              = advance(rd_idx_ff, slots_ff);
               left_in                = left_ff - SLOTS_W'(1);
               res_word.status        = STATUS_OK;
               res_word.has_event     = 1'b1;
               res_word.out_address   = ram_rd_data[3*DATA_W-1:2*DATA_W];
               res_word.out_length    = ram_rd_data[2*DATA_W-1:DATA_W];
               res_word.out_cookie    = ram_rd_data[DATA_W-1:0];
               res_word.pending_count = CAP_W'(pending_in);
               res_word.last          = (pending_in == '0) || (left_ff == SLOTS_W'(1));
               if (res_word.last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         slots_ff   <= SLOT_W'(DEPTH);
         pending_ff <= '0;
         wr_idx_ff  <= '0;
         rd_idx_ff  <= '0;
         ovf_ff     <= 1'b0;
         left_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         slots_ff   <= slots_in;
         pending_ff <= pending_in;
         wr_idx_ff  <= wr_idx_in;
         rd_idx_ff  <= rd_idx_in;
         ovf_ff     <= ovf_in;
         left_ff    <= left_in;
      end
   end

   // Event store; the read port follows the next read index so data is ready each cycle.
   erq_ram #(
      .WIDTH(RAM_W),
      .DEPTH(DEPTH)
   ) u_event_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(wr_idx_ff),
      .wr_data({op_word.address, op_word.length, op_word.cookie}),
      .rd_addr(rd_idx_in),
      .rd_data(ram_rd_data)
   );

endmodule

FILE: rtl/event_ring_queue_unit.sv
// Event ring queue: a bounded ring of events with a sticky overflow flag.
// An insert, flush or status-only result passes the operation queue and the result queue before it is visible.
// A read that returns events first moves the executor into its read state, then queues its events.
// Such a read holds the executor until it ends, returning one event a cycle while the result queue has room.
// Synchronous reset empties both queues and the ring, clears the overflow flag and
// sets the capacity to DEPTH; the event memory itself is not cleared.
`include "event_ring_queue_unit_assert.svh"

module event_ring_queue_unit
   import erq_pkg::*;
#(
   parameter int DEPTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  req_type          req_word,
   output logic             req_full,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output rsp_type          rsp_word,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CAP_W-1:0] csr_data
);

   logic    op_valid;
   op_type  op_word;
   logic    op_pop;
   logic    res_push;
   rsp_type res_word;
   logic    res_full;

   // The capacity register is always writable.
   assign csr_ready = 1'b1;

   erq_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_push(req_push),
      .req_word(req_word),
      .req_full(req_full),
      .op_valid(op_valid),
      .op_word (op_word),
      .op_pop  (op_pop)
   );

   erq_back #(
      .DEPTH(DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .csr_valid(csr_valid),
      .csr_data (csr_data),
      .op_valid (op_valid),
      .op_word  (op_word),
      .op_pop   (op_pop),
      .res_push (res_push),
      .res_word (res_word),
      .res_full (res_full)
   );

   // Result queue towards the consumer.
   erq_fifo #(
      .WIDTH($bits(rsp_type))
   ) u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (res_push),
      .push_data(res_word),
      .full     (res_full),
      .pop      (rsp_pop),
      .pop_data (rsp_word),
      .empty    (rsp_empty)
   );

   // The executor never pushes into a full result queue or takes from an empty one.
   `ERQ_ASSERT_SAME(a_push_room, res_push, !res_full, "result pushed into full queue")
   `ERQ_ASSERT_SAME(a_pop_valid, op_pop, op_valid, "operation taken from an empty queue")
   // An event result that is not the last leaves events still queued.
   `ERQ_ASSERT_SAME(a_more_pending, res_push && res_word.has_event && !res_word.last, res_word.pending_count != '0, "event read ended early")
   // Reset leaves the result side empty.
   `ERQ_ASSERT_ALWAYS(a_reset_empty, $past(reset), rsp_empty, "results present after reset")

endmodule
